// ===== design/srcd_pkg.sv =====
`default_nettype none
// ============================================================================
// srcd_pkg - shared types and constants for the shift register chain driver
// Command codes, the decoded command that travels through the command queue
// and the configuration bundle seen by both halves of the block.
// ============================================================================
package srcd_pkg;

    // default and upper bound of the number of chips in the chain
    localparam int MAX_CHIPS_DEF = 4;
    localparam int CHIP_W        = 3;   // holds any chip number up to seven
    localparam int LEN_W         = 3;   // chain length register width
    localparam int BIT_W         = 3;   // bit number within one chip
    localparam int ALL_W         = 32;  // width of the write-all word
    localparam int Q_DEPTH       = 2;   // decoded command queue depth

    localparam logic [7:0]       BYTE_ONE  = 8'h01;
    localparam logic [7:0]       BYTE_ALL  = 8'hFF;
    localparam logic [7:0]       BYTE_NONE = 8'h00;
    localparam logic [BIT_W-1:0] BIT_TOP   = 3'd7;

    // configuration register indexes
    localparam logic REG_CHAIN_LENGTH = 1'b0;
    localparam logic REG_LSB_FIRST    = 1'b1;

    typedef enum logic [3:0] {
        KIND_WRITE_BYTE  = 4'd0,
        KIND_WRITE_ALL   = 4'd1,
        KIND_LATCH       = 4'd2,
        KIND_SET_BIT     = 4'd3,
        KIND_CLEAR_BIT   = 4'd4,
        KIND_TOGGLE_BIT  = 4'd5,
        KIND_READ_BIT    = 4'd6,
        KIND_CLEAR_ALL   = 4'd7,
        KIND_SET_ALL     = 4'd8,
        KIND_SHIFT_LEFT  = 4'd9,
        KIND_SHIFT_RIGHT = 4'd10
    } t_kind;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SEND,
        BS_LATCH
    } t_bstate;

    typedef struct packed {
        logic [LEN_W-1:0] chain_len;
        logic             lsb_first;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic              is_read;
        logic [CHIP_W-1:0] chip;
        logic [BIT_W-1:0]  bit_idx;
        logic [7:0]        byte_value;
        logic [ALL_W-1:0]  all_values;
        logic              wrap;
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/shift_register_chain_driver.sv =====
`default_nettype none
// ============================================================================
// shift_register_chain_driver - shadow buffer and bit stream for a SIPO chain
// Keeps one byte per cascaded chip and turns commands into the serial
// data and latch sequence that updates the chain.
// ============================================================================
// Usage:
//  - Command channel (i_in_valid / o_in_ready) carries kind, chip and bit
//    numbers, a byte, a write-all word and the shift wrap flag. Commands that
//    are out of range or unknown are taken and dropped without any result.
//  - Result channel (o_out_valid / i_out_ready) carries serial_bit,
//    latch_pulse, read_bit and last. A flush sends 8 bits per chip in use,
//    last chip first, then one latch result marked last. A bit read gives
//    a single result.
//  - A flush occupies the sequencer while it applies the command, sends one
//    result per bit and then the latch result. The sequencer handles one
//    command at a time; a two-entry command queue lets the intake run ahead.
//  - With the sequencer idle, a command first lands in the queue register;
//    a read result is registered as it is popped, while a flush loads its
//    bit register first and registers its first bit after that.
//  - A stalled receiver holds the output register and freezes the sequencer;
//    intake continues until the queue fills.
//  - Reset clears the shadow bytes, the queue and the output valid flag, and
//    sets the chain length to 1 and the bit order to MSB first. Write the config
//    registers only while no command is in flight.
// ============================================================================
module shift_register_chain_driver
    import srcd_pkg::*;
#(
    parameter int MAX_CHIPS = MAX_CHIPS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration writes
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    // command channel
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [3:0]       i_kind,
    input  wire logic [7:0]       i_chip_index,
    input  wire logic [7:0]       i_bit_index,
    input  wire logic [7:0]       i_byte_value,
    input  wire logic [31:0]      i_all_values,
    input  wire logic             i_wrap,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_serial_bit,
    output logic                  o_latch_pulse,
    output logic                  o_read_bit,
    output logic                  o_last
);

    logic [LEN_W-1:0] r_chain_len;
    logic             r_lsb_first;
    logic [LEN_W-1:0] len_clamped;
    t_cfg             cfg;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // a length of zero or beyond the chain size falls back to one chip
    assign len_clamped = ((i_cfg_data == '0) || (i_cfg_data > LEN_W'(MAX_CHIPS)))
                         ? LEN_W'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_len <= LEN_W'(1);
            r_lsb_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHAIN_LENGTH: r_chain_len <= len_clamped;
                REG_LSB_FIRST:    r_lsb_first <= i_cfg_data[0];
                default:          r_lsb_first <= r_lsb_first;
            endcase
        end
    end

    assign cfg.chain_len = r_chain_len;
    assign cfg.lsb_first = r_lsb_first;

    // intake: classify and drop what needs no work
    srcd_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_chip_index (i_chip_index),
        .i_bit_index  (i_bit_index),
        .i_byte_value (i_byte_value),
        .i_all_values (i_all_values),
        .i_wrap       (i_wrap),
        .i_cfg        (cfg),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    // decouple intake from the sequencer
    srcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // apply the command and stream the chain
    srcd_back #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_serial_bit  (o_serial_bit),
        .o_latch_pulse (o_latch_pulse),
        .o_read_bit    (o_read_bit),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// ===== design/srcd_front.sv =====
`default_nettype none
// ============================================================================
// srcd_front - command intake and classification
// Accepts a command whenever the queue has room, drops commands that are out
// of range or unknown, and pushes the rest in decoded form.
// ============================================================================
module srcd_front
    import srcd_pkg::*;
(
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [3:0] i_kind,
    input  wire logic [7:0] i_chip_index,
    input  wire logic [7:0] i_bit_index,
    input  wire logic [7:0] i_byte_value,
    input  wire logic [31:0] i_all_values,
    input  wire logic       i_wrap,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic chip_ok;
    logic bit_ok;
    logic keep;

    assign chip_ok = i_chip_index < {{(8-LEN_W){1'b0}}, i_cfg.chain_len};
    assign bit_ok  = chip_ok && (i_bit_index <= {5'd0, BIT_TOP});

    always_comb begin
        case (i_kind)
            KIND_WRITE_BYTE: keep = chip_ok;
            KIND_SET_BIT, KIND_CLEAR_BIT, KIND_TOGGLE_BIT, KIND_READ_BIT: keep = bit_ok;
            KIND_WRITE_ALL, KIND_LATCH, KIND_CLEAR_ALL, KIND_SET_ALL,
            KIND_SHIFT_LEFT, KIND_SHIFT_RIGHT: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && keep;

    assign o_cmd.kind       = t_kind'(i_kind);
    assign o_cmd.is_read    = (i_kind == KIND_READ_BIT);
    assign o_cmd.chip       = i_chip_index[CHIP_W-1:0];
    assign o_cmd.bit_idx    = i_bit_index[BIT_W-1:0];
    assign o_cmd.byte_value = i_byte_value;
    assign o_cmd.all_values = i_all_values;
    assign o_cmd.wrap       = i_wrap;

endmodule
`default_nettype wire

// ===== design/srcd_queue.sv =====
`default_nettype none
// ============================================================================
// srcd_queue - decoded command queue
// Small register FIFO between the intake and the chain sequencer.
// ============================================================================
module srcd_queue
    import srcd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> o_full)
        else $error("full queue lost an entry without a pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with mismatched pointers");

endmodule
`default_nettype wire

// ===== design/srcd_back.sv =====
`default_nettype none
// ============================================================================
// srcd_back - shadow bytes and chain sequencer
// Applies one command to the shadow bytes, then streams the chain one bit per
// cycle while not stalled, then the latch result, or returns one read result.
// ============================================================================
module srcd_back
    import srcd_pkg::*;
#(
    parameter int MAX_CHIPS = MAX_CHIPS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output logic      o_serial_bit,
    output logic      o_latch_pulse,
    output logic      o_read_bit,
    output logic      o_last
);

    localparam int FLUSH_W = 8 * MAX_CHIPS;
    localparam int CNT_W   = $clog2(FLUSH_W + 1);

    logic [7:0]         r_shadow [MAX_CHIPS];
    logic [7:0]         upd      [MAX_CHIPS];
    t_bstate            r_state, n_state;
    logic [FLUSH_W-1:0] r_flush, n_flush;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic               r_serial, n_serial;
    logic               r_latch, n_latch;
    logic               r_read, n_read;
    logic               r_last, n_last;

    logic [FLUSH_W-1:0] old_flat;
    logic [FLUSH_W:0]   shl_pad;
    logic [FLUSH_W:0]   shr_pad;
    logic [FLUSH_W-1:0] ord_flat;
    logic [FLUSH_W-1:0] all_pad;
    logic [LEN_W-1:0]   last_chip;
    logic               top7;
    logic               rd_bit;
    logic               out_free;
    logic               pop;

    assign last_chip = i_cfg.chain_len - 1'b1;
    assign all_pad   = FLUSH_W'(i_cmd.all_values);
    assign shl_pad   = {old_flat, 1'b0};
    assign shr_pad   = {1'b0, old_flat};

    // flatten and pick the addressed bits
    always_comb begin
        top7   = 1'b0;
        rd_bit = 1'b0;
        for (int i = 0; i < MAX_CHIPS; i++) begin
            old_flat[8*i +: 8] = r_shadow[i];
            if (LEN_W'(i) == last_chip) begin
                top7 = r_shadow[i][7];
            end
            if (CHIP_W'(i) == i_cmd.chip) begin
                rd_bit = r_shadow[i][i_cmd.bit_idx];
            end
        end
    end

    // new shadow bytes, one chip at a time
    always_comb begin
        for (int i = 0; i < MAX_CHIPS; i++) begin
            logic       in_use;
            logic       hit;
            logic [7:0] mask;
            logic       cin;
            in_use = LEN_W'(i) < i_cfg.chain_len;
            hit    = CHIP_W'(i) == i_cmd.chip;
            mask   = BYTE_ONE << i_cmd.bit_idx;
            upd[i] = r_shadow[i];
            cin    = 1'b0;
            case (i_cmd.kind)
                KIND_WRITE_BYTE:  if (hit) upd[i] = i_cmd.byte_value;
                KIND_WRITE_ALL:   if (in_use) upd[i] = all_pad[8*i +: 8];
                KIND_SET_BIT:     if (hit) upd[i] = r_shadow[i] | mask;
                KIND_CLEAR_BIT:   if (hit) upd[i] = r_shadow[i] & ~mask;
                KIND_TOGGLE_BIT:  if (hit) upd[i] = r_shadow[i] ^ mask;
                KIND_CLEAR_ALL:   if (in_use) upd[i] = BYTE_NONE;
                KIND_SET_ALL:     if (in_use) upd[i] = BYTE_ALL;
                KIND_SHIFT_LEFT: begin
                    cin = shl_pad[8*i] | ((i == 0) && i_cmd.wrap && top7);
                    if (in_use) upd[i] = {r_shadow[i][6:0], cin};
                end
                KIND_SHIFT_RIGHT: begin
                    cin = (LEN_W'(i) == last_chip) ? (i_cmd.wrap && old_flat[0])
                                                   : shr_pad[8*(i+1)];
                    if (in_use) upd[i] = {cin, r_shadow[i][7:1]};
                end
                default: upd[i] = r_shadow[i];
            endcase
        end
    end

    // bit order of the outgoing stream, first bit at the top
    always_comb begin
        for (int i = 0; i < MAX_CHIPS; i++) begin
            for (int b = 0; b < 8; b++) begin
                ord_flat[8*i + b] = i_cfg.lsb_first ? upd[i][7-b] : upd[i][b];
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_flush     = r_flush;
        n_count     = r_count;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        n_serial    = r_serial;
        n_latch     = r_latch;
        n_read      = r_read;
        n_last      = r_last;
        pop         = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    pop = 1'b1;
                    if (i_cmd.is_read) begin
                        n_out_valid = 1'b1;
                        n_serial    = 1'b0;
                        n_latch     = 1'b0;
                        n_read      = rd_bit;
                        n_last      = 1'b1;
                    end else begin
                        n_flush = ord_flat << (FLUSH_W - 8 * int'(i_cfg.chain_len));
                        n_count = CNT_W'({i_cfg.chain_len, 3'b000});
                        n_state = BS_SEND;
                    end
                end
            end
            BS_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_serial    = r_flush[FLUSH_W-1];
                    n_latch     = 1'b0;
                    n_read      = 1'b0;
                    n_last      = 1'b0;
                    n_flush     = r_flush << 1;
                    n_count     = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_state = BS_LATCH;
                    end
                end
            end
            BS_LATCH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_serial    = 1'b0;
                    n_latch     = 1'b1;
                    n_read      = 1'b0;
                    n_last      = 1'b1;
                    n_state     = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_CHIPS; i++) begin
                r_shadow[i] <= BYTE_NONE;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (pop) begin
                for (int i = 0; i < MAX_CHIPS; i++) begin
                    r_shadow[i] <= upd[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flush  <= n_flush;
        r_count  <= n_count;
        r_serial <= n_serial;
        r_latch  <= n_latch;
        r_read   <= n_read;
        r_last   <= n_last;
    end

    assign o_cmd_pop     = pop;
    assign o_out_valid   = r_out_valid;
    assign o_serial_bit  = r_serial;
    assign o_latch_pulse = r_latch;
    assign o_read_bit    = r_read;
    assign o_last        = r_last;

    a_send_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SEND) |-> (r_count != '0))
        else $error("sending with an empty bit count");

    a_latch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_latch |-> r_last && !r_read && !r_serial)
        else $error("latch result not marked as final");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_state == BS_IDLE))
        else $error("command taken during a flush");

    a_latch_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_LATCH) && out_free |=> (r_state == BS_IDLE) && r_latch)
        else $error("latch step did not close the flush");

endmodule
`default_nettype wire
